@@ sv/tlb_pkg.sv @@
`default_nettype none
package tlb_pkg;

  localparam int TLB_ENTRIES  = 16;
  localparam int FRAME_COUNT  = 128;
  localparam int OFFSET_WIDTH = 8;

  localparam int VA_WIDTH    = 16;
  localparam int PA_WIDTH    = 15;
  localparam int PAGE_WIDTH  = 8;
  localparam int PAGE_COUNT  = 1 << PAGE_WIDTH;
  localparam int COUNT_WIDTH = 32;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int FRAME_W     = $clog2(FRAME_COUNT);

  localparam logic [VA_WIDTH-1:0] OFFSET_LOW_BITS =
    VA_WIDTH'((64'd1 << OFFSET_WIDTH) - 64'd1);

  typedef struct packed {
    logic capture;
    logic resolve;
  } tlb_cmd_t;

endpackage
`default_nettype wire

@@ sv/tlb_page_translation_unit.sv @@
// Channel      Handshake          Payload
// input        start, busy        virtual_address
// result       done               physical_address, tlb_hit, page_fault, fault_page,
//                                 hit_count, fault_count, access_count
//
// A transaction is accepted at the edge where start is high and busy is low.
// In each transaction the TLB compare and the page map and frame table reads
// happen at the accepting edge, and all updates and the result register load
// at the next edge, where done also rises.
// Reset is synchronous and empties the TLB, the page map and the frame table.
// The receiver cannot stall: done lasts one cycle and the result holds after.
`default_nettype none
module tlb_page_translation_unit
  import tlb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VA_WIDTH-1:0]    virtual_address,
  output logic                        done,
  output logic [PA_WIDTH-1:0]         physical_address,
  output logic                        tlb_hit,
  output logic                        page_fault,
  output logic [PAGE_WIDTH-1:0]       fault_page,
  output logic [COUNT_WIDTH-1:0]      hit_count,
  output logic [COUNT_WIDTH-1:0]      fault_count,
  output logic [COUNT_WIDTH-1:0]      access_count
);

  tlb_cmd_t cmd;

  tlb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tlb_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .virtual_address  (virtual_address),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .fault_page       (fault_page),
    .hit_count        (hit_count),
    .fault_count      (fault_count),
    .access_count     (access_count)
  );

endmodule
`default_nettype wire

@@ sv/tlb_ctrl.sv @@
`default_nettype none
module tlb_ctrl
  import tlb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  output tlb_cmd_t      cmd
);

  typedef enum logic {
    IDLE,
    RESOLVE
  } state_t;

  state_t state;

  always_comb begin
    busy        = (state == RESOLVE);
    cmd.capture = start && (state == IDLE);
    cmd.resolve = (state == RESOLVE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= cmd.resolve;
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= RESOLVE;
          end
        end
        RESOLVE: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/tlb_datapath.sv @@
`default_nettype none
module tlb_datapath
  import tlb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tlb_cmd_t               cmd,
  input  wire logic [VA_WIDTH-1:0]    virtual_address,
  output logic [PA_WIDTH-1:0]         physical_address,
  output logic                        tlb_hit,
  output logic                        page_fault,
  output logic [PAGE_WIDTH-1:0]       fault_page,
  output logic [COUNT_WIDTH-1:0]      hit_count,
  output logic [COUNT_WIDTH-1:0]      fault_count,
  output logic [COUNT_WIDTH-1:0]      access_count
);

  logic [VA_WIDTH-1:0]   va_shifted;
  logic [PAGE_WIDTH-1:0] va_page;

  logic [PAGE_WIDTH-1:0] page_q;
  logic [VA_WIDTH-1:0]   offset_q;

  logic                  tlb_valid [TLB_ENTRIES];
  logic [PAGE_WIDTH-1:0] tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]    tlb_frame [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0]  tlb_fill_pointer;

  logic                  tlb_match;
  logic [FRAME_W-1:0]    tlb_match_frame;
  logic                  tlb_hit_q;
  logic [FRAME_W-1:0]    tlb_frame_q;

  logic [PAGE_COUNT-1:0] rev_valid;
  logic [PAGE_COUNT-1:0] rev_valid_next;
  logic [FRAME_W-1:0]    rev_frame [PAGE_COUNT];
  logic                  rev_hit_q;
  logic [FRAME_W-1:0]    rev_frame_q;

  logic [PAGE_WIDTH-1:0] frame_page [FRAME_COUNT];
  logic [PAGE_WIDTH-1:0] old_page_q;
  logic [FRAME_W-1:0]    next_frame;
  logic                  frames_full;

  logic [COUNT_WIDTH-1:0] hits_total;
  logic [COUNT_WIDTH-1:0] faults_total;
  logic [COUNT_WIDTH-1:0] accesses_total;

  logic                  fault;
  logic [FRAME_W-1:0]    frame;
  logic [63:0]           phys_wide;

  assign va_shifted = virtual_address >> OFFSET_WIDTH;
  assign va_page    = va_shifted[PAGE_WIDTH-1:0];

  // The lowest matching entry wins, so the scan runs from the top down.
  always_comb begin
    tlb_match       = 1'b0;
    tlb_match_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_page[i] == va_page)) begin
        tlb_match       = 1'b1;
        tlb_match_frame = tlb_frame[i];
      end
    end
  end

  always_comb begin
    fault = !tlb_hit_q && !rev_hit_q;
    priority if (tlb_hit_q) begin
      frame = tlb_frame_q;
    end else if (rev_hit_q) begin
      frame = rev_frame_q;
    end else begin
      frame = next_frame;
    end
    phys_wide = (64'(frame) << OFFSET_WIDTH) | 64'(offset_q);
  end

  // A reused frame drops the page it held before.
  always_comb begin
    rev_valid_next = rev_valid;
    if (frames_full) begin
      rev_valid_next[old_page_q] = 1'b0;
    end
    rev_valid_next[page_q] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q      <= va_page;
      offset_q    <= virtual_address & OFFSET_LOW_BITS;
      tlb_hit_q   <= tlb_match;
      tlb_frame_q <= tlb_match_frame;
      rev_hit_q   <= rev_valid[va_page];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rev_frame_q <= rev_frame[va_page];
    end
    if (cmd.resolve && fault) begin
      rev_frame[page_q] <= next_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      old_page_q <= frame_page[next_frame];
    end
    if (cmd.resolve && fault) begin
      frame_page[next_frame] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && !tlb_hit_q) begin
      tlb_page[tlb_fill_pointer]  <= page_q;
      tlb_frame[tlb_fill_pointer] <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      physical_address <= phys_wide[PA_WIDTH-1:0];
      tlb_hit          <= tlb_hit_q;
      page_fault       <= fault;
      fault_page       <= fault ? page_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
      end
      tlb_fill_pointer <= '0;
      rev_valid        <= '0;
      next_frame       <= '0;
      frames_full      <= 1'b0;
      hits_total       <= '0;
      faults_total     <= '0;
      accesses_total   <= '0;
    end else if (cmd.resolve) begin
      accesses_total <= accesses_total + 1'b1;
      if (tlb_hit_q) begin
        hits_total <= hits_total + 1'b1;
      end else begin
        tlb_valid[tlb_fill_pointer] <= 1'b1;
        if (tlb_fill_pointer == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
          tlb_fill_pointer <= '0;
        end else begin
          tlb_fill_pointer <= tlb_fill_pointer + 1'b1;
        end
      end
      if (fault) begin
        faults_total <= faults_total + 1'b1;
        rev_valid    <= rev_valid_next;
        if (next_frame == FRAME_W'(FRAME_COUNT - 1)) begin
          next_frame  <= '0;
          frames_full <= 1'b1;
        end else begin
          next_frame <= next_frame + 1'b1;
        end
      end
    end
  end

  assign hit_count    = hits_total;
  assign fault_count  = faults_total;
  assign access_count = accesses_total;

endmodule
`default_nettype wire

@@ bench/tlb_translation_checker.sv @@
`timescale 1ns / 100ps
module tlb_translation_checker
  import tlb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [VA_WIDTH-1:0]    virtual_address,
  input  logic                   done,
  input  logic [PA_WIDTH-1:0]    physical_address,
  input  logic                   tlb_hit,
  input  logic                   page_fault,
  input  logic [PAGE_WIDTH-1:0]  fault_page,
  input  logic [COUNT_WIDTH-1:0] hit_count,
  input  logic [COUNT_WIDTH-1:0] fault_count,
  input  logic [COUNT_WIDTH-1:0] access_count,
  output int                     errors,
  output int                     outstanding
);

  typedef struct packed {
    logic [PA_WIDTH-1:0]    pa;
    logic                   hit;
    logic                   fault;
    logic [PAGE_WIDTH-1:0]  fpage;
    logic [COUNT_WIDTH-1:0] hits;
    logic [COUNT_WIDTH-1:0] faults;
    logic [COUNT_WIDTH-1:0] accesses;
  } translation_t;

  logic                   tlb_ok   [TLB_ENTRIES];
  logic [PAGE_WIDTH-1:0]  tlb_pg   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frm  [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0]   fill_slot;
  logic                   frame_used [FRAME_COUNT];
  logic [PAGE_WIDTH-1:0]  frame_pg   [FRAME_COUNT];
  logic [FRAME_W-1:0]     rr_frame;
  logic [COUNT_WIDTH-1:0] hits_seen;
  logic [COUNT_WIDTH-1:0] faults_seen;
  logic [COUNT_WIDTH-1:0] accesses_seen;

  translation_t expected_translations[$];

  function void clear_tables();
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_ok[i] = 1'b0;
      tlb_pg[i] = '0;
      tlb_frm[i] = '0;
    end
    for (int i = 0; i < FRAME_COUNT; i++) begin
      frame_used[i] = 1'b0;
      frame_pg[i] = '0;
    end
    fill_slot = '0;
    rr_frame = '0;
    hits_seen = '0;
    faults_seen = '0;
    accesses_seen = '0;
  endfunction

  function translation_t translate_address(input logic [VA_WIDTH-1:0] va);
    translation_t t;
    logic [PAGE_WIDTH-1:0] page;
    logic [VA_WIDTH-1:0] offset;
    logic [FRAME_W-1:0] frame;
    logic found;
    logic [31:0] wide_pa;
    page = PAGE_WIDTH'(va >> OFFSET_WIDTH);
    offset = va & OFFSET_LOW_BITS;
    frame = '0;
    found = 1'b0;
    t = '0;
    accesses_seen = accesses_seen + 1;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!found && tlb_ok[i] && tlb_pg[i] == page) begin
        found = 1'b1;
        frame = tlb_frm[i];
      end
    end
    if (found) begin
      t.hit = 1'b1;
      hits_seen = hits_seen + 1;
    end else begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (!found && frame_used[i] && frame_pg[i] == page) begin
          found = 1'b1;
          frame = FRAME_W'(i);
        end
      end
      if (!found) begin
        t.fault = 1'b1;
        t.fpage = page;
        frame = rr_frame;
        rr_frame = rr_frame + 1;
        frame_used[frame] = 1'b1;
        frame_pg[frame] = page;
        faults_seen = faults_seen + 1;
      end
      tlb_ok[fill_slot] = 1'b1;
      tlb_pg[fill_slot] = page;
      tlb_frm[fill_slot] = frame;
      fill_slot = fill_slot + 1;
    end
    wide_pa = (32'(frame) << OFFSET_WIDTH) | 32'(offset);
    t.pa = PA_WIDTH'(wide_pa);
    t.hits = hits_seen;
    t.faults = faults_seen;
    t.accesses = accesses_seen;
    return t;
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      errors = errors + 1;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
    clear_tables();
  end

  always @(posedge clk) begin
    translation_t want;
    if (rst) begin
      clear_tables();
      expected_translations.delete();
    end else begin
      if (done) begin
        if (expected_translations.size() == 0) begin
          errors = errors + 1;
          $display("%0t: result with no transaction pending, pa %0h", $time,
                   physical_address);
        end else begin
          want = expected_translations.pop_front();
          check_field("physical_address", want.pa, physical_address);
          check_field("tlb_hit", want.hit, tlb_hit);
          check_field("page_fault", want.fault, page_fault);
          check_field("fault_page", want.fpage, fault_page);
          check_field("hit_count", want.hits, hit_count);
          check_field("fault_count", want.faults, fault_count);
          check_field("access_count", want.accesses, access_count);
        end
      end
      if (start && !busy) expected_translations.push_back(translate_address(virtual_address));
    end
    outstanding = expected_translations.size();
  end

endmodule

@@ bench/tb_tlb_page_translation_unit.sv @@
`timescale 1ns / 100ps
module tb_tlb_page_translation_unit;
  import tlb_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [VA_WIDTH-1:0]    virtual_address = '0;
  logic                   done;
  logic [PA_WIDTH-1:0]    physical_address;
  logic                   tlb_hit;
  logic                   page_fault;
  logic [PAGE_WIDTH-1:0]  fault_page;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [COUNT_WIDTH-1:0] fault_count;
  logic [COUNT_WIDTH-1:0] access_count;
  int                     errors;
  int                     outstanding;
  int                     cycles = 0;

  always #1 clk = ~clk;

  tlb_page_translation_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .virtual_address(virtual_address), .done(done),
    .physical_address(physical_address), .tlb_hit(tlb_hit),
    .page_fault(page_fault), .fault_page(fault_page), .hit_count(hit_count),
    .fault_count(fault_count), .access_count(access_count)
  );

  tlb_translation_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .virtual_address(virtual_address), .done(done),
    .physical_address(physical_address), .tlb_hit(tlb_hit),
    .page_fault(page_fault), .fault_page(fault_page), .hit_count(hit_count),
    .fault_count(fault_count), .access_count(access_count),
    .errors(errors), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_address(input logic [VA_WIDTH-1:0] va);
    start <= 1'b1;
    virtual_address <= va;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    virtual_address <= VA_WIDTH'($urandom);
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [VA_WIDTH-1:0] pick_address(input logic [PAGE_WIDTH-1:0] hot_base,
                                                       input logic [PAGE_WIDTH-1:0] warm_base);
    int choice;
    logic [PAGE_WIDTH-1:0] page;
    choice = $urandom_range(0, 99);
    if (choice < 35) page = hot_base + PAGE_WIDTH'($urandom_range(0, 5));
    else if (choice < 65) page = warm_base + PAGE_WIDTH'($urandom_range(0, 63));
    else return VA_WIDTH'($urandom);
    return {page, 8'(($urandom))};
  endfunction

  initial begin
    logic [VA_WIDTH-1:0] directed[$];
    logic [PAGE_WIDTH-1:0] hot_base;
    logic [PAGE_WIDTH-1:0] warm_base;
    int sent;
    int burst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Extremes, repeated pages for TLB hits, then enough new pages to push
    // page zero out of the TLB so that it is found in the frame table.
    directed = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'h8000,
                 16'h7FFF, 16'h5555, 16'hAAAA};
    for (int i = 0; i < 11; i++) directed.push_back({8'(8'h10 + i), 8'(i * 23)});
    directed.push_back(16'h0042);
    directed.push_back(16'hFF80);
    foreach (directed[i]) begin
      issue_address(directed[i]);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
    end

    hot_base = 8'(($urandom));
    warm_base = 8'(($urandom));
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        issue_address(pick_address(hot_base, warm_base));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) hot_base = 8'(($urandom));
      if ($urandom_range(0, 19) == 0) warm_base = 8'(($urandom));
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tlb_pkg.sv
sv/tlb_ctrl.sv
sv/tlb_datapath.sv
sv/tlb_page_translation_unit.sv
bench/tlb_translation_checker.sv
bench/tb_tlb_page_translation_unit.sv
